[hdl/arp_pkg.sv]
// Shared types and constants of the ARP request responder.
`default_nettype none

package arp_pkg;

   // Frame layout.
   localparam logic [5:0] HDR_LEN = 6'd42;
   localparam int unsigned FIELD_BASE = 12;
   localparam int unsigned FIELD_SLOTS = 30;
   localparam logic [15:0] ETH_ARP = 16'h0806;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
   localparam logic [15:0] OPCODE_REPLY = 16'h0002;

   // Reply framing.
   localparam logic [2:0] LAST_WORD = 3'd5;
   localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
   localparam logic [3:0] LAST_WORD_BYTES = 4'd2;

   // Register reset values.
   localparam logic [47:0] GATEWAY_MAC_RESET = 48'h52550a000202;
   localparam logic [31:0] GATEWAY_IP_RESET = 32'h0a000202;
   localparam logic [31:0] DNS_IP_RESET = 32'h0a000203;

   // Register indexes, taken from address bits [4:3].
   localparam logic [1:0] REG_GATEWAY_MAC = 2'd0;
   localparam logic [1:0] REG_GATEWAY_IP = 2'd1;
   localparam logic [1:0] REG_DNS_IP = 2'd2;

   // Job queue between the receive and transmit sides.
   localparam logic [1:0] JOB_FIFO_DEPTH = 2'd2;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [63:0] reply_word;
      logic [3:0]  byte_count;
      logic        reply_end;
   } rsp_type;

   // Everything the transmit side needs from an accepted request.
   typedef struct packed {
      logic [47:0] hw_info;   // hardware type, protocol type, lengths
      logic [47:0] sha;       // requester MAC
      logic [31:0] spa;       // requester IP
      logic [31:0] tpa;       // claimed IP
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } job_push_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] level;
      job_type    job;
   } job_head_type;

endpackage

`default_nettype wire

[hdl/arp_rx_front.sv]
// Receive side: captures header bytes and classifies each finished frame.
`default_nettype none

module arp_rx_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire arp_pkg::req_type      req_data,
   input  wire logic [31:0]           gateway_ip,
   input  wire logic [31:0]           dns_ip,
   input  wire logic [1:0]            fifo_level,
   output arp_pkg::job_push_type      job_push
);

   logic [5:0] bytes_seen_ff, bytes_seen_in;
   logic       done_ff, done_in;
   logic [7:0] field_ff [arp_pkg::FIELD_SLOTS];
   logic       accept;
   logic [15:0] ethertype, opcode;
   logic [31:0] tpa;
   logic        match;

   assign accept = req_valid & req_ready;

   // Room is reserved for the frame still being classified.
   assign req_ready = ({1'b0, fifo_level} + {2'b00, done_ff}) < {1'b0, arp_pkg::JOB_FIFO_DEPTH};

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            bytes_seen_in = 6'd0;
         end else if (bytes_seen_ff < arp_pkg::HDR_LEN) begin
            bytes_seen_in = bytes_seen_ff + 6'd1;
         end
      end
   end

   // The final byte completes a full header if it is at least the 42nd byte.
   assign done_in = accept & req_data.frame_end &
                    (bytes_seen_ff >= (arp_pkg::HDR_LEN - 6'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= 6'd0;
         done_ff       <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < arp_pkg::FIELD_SLOTS; k++) begin
         if (accept && (bytes_seen_ff == 6'(k + arp_pkg::FIELD_BASE))) begin
            field_ff[k] <= req_data.frame_byte;
         end
      end
   end

   // Fields stay stable while the finished frame is classified: the next frame
   // overwrites them only from its byte 12 on.
   assign ethertype = {field_ff[0], field_ff[1]};
   assign opcode    = {field_ff[8], field_ff[9]};
   assign tpa       = {field_ff[26], field_ff[27], field_ff[28], field_ff[29]};
   assign match     = (ethertype == arp_pkg::ETH_ARP) &&
                      (opcode == arp_pkg::OPCODE_REQUEST) &&
                      ((tpa == gateway_ip) || (tpa == dns_ip));

   assign job_push.push        = done_ff & match;
   assign job_push.job.hw_info = {field_ff[2], field_ff[3], field_ff[4],
                                  field_ff[5], field_ff[6], field_ff[7]};
   assign job_push.job.sha     = {field_ff[10], field_ff[11], field_ff[12],
                                  field_ff[13], field_ff[14], field_ff[15]};
   assign job_push.job.spa     = {field_ff[16], field_ff[17], field_ff[18], field_ff[19]};
   assign job_push.job.tpa     = tpa;

endmodule

`default_nettype wire

[hdl/arp_job_fifo.sv]
// Two-entry queue of accepted requests between receive and transmit sides.
`default_nettype none

module arp_job_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire arp_pkg::job_push_type  job_push,
   input  wire logic                   pop,
   output arp_pkg::job_head_type       head
);

   arp_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (job_push.push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (job_push.push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (!job_push.push && pop) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_push.push) begin
         entry_ff[wr_ptr_ff] <= job_push.job;
      end
   end

   assign head.valid = (level_ff != 2'd0);
   assign head.level = level_ff;
   assign head.job   = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hdl/arp_tx_back.sv]
// Transmit side: turns a queued request into six reply words.
`default_nettype none

module arp_tx_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire arp_pkg::job_head_type  head,
   input  wire logic [47:0]            gateway_mac,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output arp_pkg::rsp_type            rsp_data
);

   logic [2:0]       word_ff, word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   arp_pkg::rsp_type rsp_ff, rsp_in;
   logic [383:0]     reply_vec;
   logic [8:0]       word_base;
   logic             load;
   logic             last;

   // Whole 48-byte reply, first wire byte at the top; the tail is padding.
   assign reply_vec = {head.job.sha, gateway_mac, arp_pkg::ETH_ARP, head.job.hw_info,
                       arp_pkg::OPCODE_REPLY, gateway_mac, head.job.tpa,
                       head.job.sha, head.job.spa, 48'h0};

   assign word_base = {arp_pkg::LAST_WORD - word_ff, 6'd0};
   assign last      = (word_ff == arp_pkg::LAST_WORD);
   assign load      = head.valid & (~rsp_valid_ff | rsp_ready);
   assign pop       = load & last;

   always_comb begin
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      if (load) begin
         word_in             = last ? 3'd0 : word_ff + 3'd1;
         rsp_valid_in        = 1'b1;
         rsp_in.reply_word   = reply_vec[word_base +: 64];
         rsp_in.byte_count   = last ? arp_pkg::LAST_WORD_BYTES : arp_pkg::FULL_WORD_BYTES;
         rsp_in.reply_end    = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hdl/arp_request_responder.sv]
// Top level of the ARP request responder.
//
// The req channel takes one Ethernet frame byte per item, in wire order, with
// frame_end set on the final byte; req_ready stays high while the job queue has
// room, so a receive MAC can stream one byte every cycle. The first 42 bytes
// are counted and bytes 12 to 41 stored; further bytes are dropped until the
// end of the frame. A frame that is at least 42 bytes long, carries ethertype
// 0x0806, opcode 1 and a target address equal to gateway_ip or dns_ip
// produces a reply: six items on the rsp channel, 64 bits each, earliest byte
// on top, the last one holding two valid bytes and reply_end. Other frames
// produce nothing. A finished frame is classified from the done register,
// queued in the job queue and then loaded into the output register. Words
// then leave at one per cycle while rsp_ready is high. A stalled receiver
// holds the output register; up to two classified replies wait in the job
// queue, and req_ready drops only when that queue could overflow.
// Reset clears the byte counter, the queue and the output valid, and restores
// the three registers (64-bit data, byte addresses 0, 8 and 16) to their
// defaults. Registers should be written only while no reply is in flight.
`default_nettype none

module arp_request_responder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire arp_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output arp_pkg::rsp_type       rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [4:0]        csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [47:0] gateway_mac_ff;
   logic [31:0] gateway_ip_ff;
   logic [31:0] dns_ip_ff;
   logic [1:0]  reg_index;
   logic        csr_write;

   arp_pkg::job_push_type job_push;
   arp_pkg::job_head_type job_head;
   logic                  pop;

   // Register file. Bits [4:3] of the address select the register; an index
   // past the last register is ignored on write and reads as zero.
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gateway_mac_ff <= arp_pkg::GATEWAY_MAC_RESET;
         gateway_ip_ff  <= arp_pkg::GATEWAY_IP_RESET;
         dns_ip_ff      <= arp_pkg::DNS_IP_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            arp_pkg::REG_GATEWAY_MAC: gateway_mac_ff <= csr_pwdata[47:0];
            arp_pkg::REG_GATEWAY_IP:  gateway_ip_ff  <= csr_pwdata[31:0];
            arp_pkg::REG_DNS_IP:      dns_ip_ff      <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         arp_pkg::REG_GATEWAY_MAC: csr_prdata = {16'h0, gateway_mac_ff};
         arp_pkg::REG_GATEWAY_IP:  csr_prdata = {32'h0, gateway_ip_ff};
         arp_pkg::REG_DNS_IP:      csr_prdata = {32'h0, dns_ip_ff};
         default:                  csr_prdata = 64'h0;
      endcase
   end

   // Receive side: header capture and frame classification.
   arp_rx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .gateway_ip (gateway_ip_ff),
      .dns_ip     (dns_ip_ff),
      .fifo_level (job_head.level),
      .job_push   (job_push)
   );

   // Accepted requests wait here so each side can stall on its own.
   arp_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .job_push (job_push),
      .pop      (pop),
      .head     (job_head)
   );

   // Transmit side: reply word generation behind an output register.
   arp_tx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (job_head),
      .gateway_mac (gateway_mac_ff),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/arp_checker.sv]
// Port-level checker for the ARP request responder, bound to the top level.
`default_nettype none

module arp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire arp_pkg::rsp_type  rsp_data
);

   logic [2:0] word_ff, word_in;

   // Position of the next reply word within its frame.
   always_comb begin
      word_in = word_ff;
      if (rsp_valid && rsp_ready) begin
         word_in = rsp_data.reply_end ? 3'd0 : word_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= 3'd0;
      end else begin
         word_ff <= word_in;
      end
   end

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply item valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled reply item changed");

   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.reply_end == (word_ff == arp_pkg::LAST_WORD)) &&
                    (rsp_data.byte_count == ((word_ff == arp_pkg::LAST_WORD) ?
                       arp_pkg::LAST_WORD_BYTES : arp_pkg::FULL_WORD_BYTES)))
      else $error("reply frame is not six words ending in a two-byte word");

   a_fixed_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (word_ff == 3'd1) |-> rsp_data.reply_word[31:16] == arp_pkg::ETH_ARP)
      else $error("reply ethertype is wrong");

   a_reply_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (word_ff == 3'd2) |-> rsp_data.reply_word[31:16] == arp_pkg::OPCODE_REPLY)
      else $error("reply opcode is wrong");

endmodule

bind arp_request_responder arp_checker u_arp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[sim/arp_request_responder_test.sv]
// Self-checking testbench for the ARP request responder.
`default_nettype none

module arp_request_responder_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off at this cycle count even if replies are still due.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Cycles allowed after the last expected reply word before the block is
   // taken to be idle.
   localparam int unsigned DRAIN_TAIL = 8;
   // Address bits [4:3] = 3 decode to no register and must be ignored.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef logic [7:0] frame_bytes_type[$];

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   arp_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   arp_pkg::rsp_type  rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [4:0]        csr_paddr = '0;
   logic [63:0]       csr_pwdata = '0;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   // Percent of cycles in which the sender holds back or the receiver stalls.
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   // Our own copy of the responder: registers, header capture and the reply
   // words still owed by the block, oldest first.
   logic [47:0]   answer_mac = arp_pkg::GATEWAY_MAC_RESET;
   logic [31:0]   gateway_addr = arp_pkg::GATEWAY_IP_RESET;
   logic [31:0]   dns_addr = arp_pkg::DNS_IP_RESET;
   logic [7:0]    header_bytes [0:int'(arp_pkg::HDR_LEN)-1];
   logic [5:0]    header_fill = '0;
   arp_pkg::rsp_type reply_words_due[$];

   int unsigned   cycle_count = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   frames_seen = 0;
   int unsigned   replies_predicted = 0;
   int unsigned   words_checked = 0;

   arp_request_responder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2ns clock = ~clock;

   // A hung block must not hang the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reply words outstanding",
                  cycle_count, reply_words_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Takes one accepted frame byte. On the closing byte of a frame that
   // is a claimed ARP request, the six reply words are queued.
   function automatic void predict_frame_byte(input arp_pkg::req_type item);
      logic [7:0]       reply [0:47];
      logic [31:0]      target;
      arp_pkg::rsp_type word;
      logic             complete;
      int               i;
      int               w;
      if (header_fill < arp_pkg::HDR_LEN) begin
         header_bytes[header_fill] = item.frame_byte;
         header_fill = header_fill + 6'd1;
      end
      if (!item.frame_end) return;
      // The capture restarts after every frame, whatever the outcome.
      complete = (header_fill == arp_pkg::HDR_LEN);
      header_fill = '0;
      frames_seen++;
      if (!complete) return;
      if ({header_bytes[12], header_bytes[13]} != arp_pkg::ETH_ARP) return;
      if ({header_bytes[20], header_bytes[21]} != arp_pkg::OPCODE_REQUEST) return;
      target = {header_bytes[38], header_bytes[39], header_bytes[40], header_bytes[41]};
      if (target != gateway_addr && target != dns_addr) return;

      // The bytes of the last word past the two valid ones stay zero.
      for (i = 0; i < 48; i++) reply[i] = 8'h00;
      for (i = 0; i < 6; i++) begin
         reply[i] = header_bytes[22 + i];
         reply[6 + i] = answer_mac[47 - 8 * i -: 8];
         reply[14 + i] = header_bytes[14 + i];
         reply[22 + i] = answer_mac[47 - 8 * i -: 8];
         reply[32 + i] = header_bytes[22 + i];
      end
      reply[12] = arp_pkg::ETH_ARP[15:8];
      reply[13] = arp_pkg::ETH_ARP[7:0];
      reply[20] = arp_pkg::OPCODE_REPLY[15:8];
      reply[21] = arp_pkg::OPCODE_REPLY[7:0];
      for (i = 0; i < 4; i++) begin
         reply[28 + i] = header_bytes[38 + i];
         reply[38 + i] = header_bytes[28 + i];
      end
      for (w = 0; w < 6; w++) begin
         word.reply_word = '0;
         for (i = 0; i < 8; i++) word.reply_word = {word.reply_word[55:0], reply[8 * w + i]};
         word.byte_count = (w == int'(arp_pkg::LAST_WORD)) ?
                           arp_pkg::LAST_WORD_BYTES : arp_pkg::FULL_WORD_BYTES;
         word.reply_end = (w == int'(arp_pkg::LAST_WORD));
         reply_words_due = {reply_words_due, word};
      end
      replies_predicted++;
   endfunction

   function automatic logic [63:0] register_value(input logic [1:0] index);
      case (index)
         arp_pkg::REG_GATEWAY_MAC: return {16'h0000, answer_mac};
         arp_pkg::REG_GATEWAY_IP:  return {32'h0, gateway_addr};
         arp_pkg::REG_DNS_IP:      return {32'h0, dns_addr};
         default:                  return '0;
      endcase
   endfunction

   // Receiver: ready is redrawn every falling edge; a word is taken at a
   // rising edge with valid and ready both high and checked right there.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      arp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reply_words_due.size() == 0) begin
            report_mismatch($sformatf("reply word %h with no reply pending",
                                      rsp_data.reply_word));
         end else begin
            want = reply_words_due.pop_front();
            words_checked++;
            if (rsp_data.reply_word !== want.reply_word)
               report_mismatch($sformatf("reply_word %h, expected %h",
                                         rsp_data.reply_word, want.reply_word));
            if (rsp_data.byte_count !== want.byte_count)
               report_mismatch($sformatf("byte_count %0d, expected %0d",
                                         rsp_data.byte_count, want.byte_count));
            if (rsp_data.reply_end !== want.reply_end)
               report_mismatch($sformatf("reply_end %b, expected %b",
                                         rsp_data.reply_end, want.reply_end));
         end
      end
   end

   // Offers one frame byte, with random holdback before it, and hands it to
   // the predictor at the edge where it is accepted. Valid is left high so
   // that the next byte can follow in the very next cycle.
   task automatic send_byte(input logic [7:0] value, input logic last);
      arp_pkg::req_type item;
      item.frame_byte = value;
      item.frame_end = last;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data <= {8'($urandom), 1'($urandom)};
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predict_frame_byte(item);
   endtask

   task automatic send_frame(input frame_bytes_type frame);
      int i;
      for (i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // Drops valid, waits for every owed reply word and then lets the block
   // settle, so that a frame that yields nothing has finished too.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (reply_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // An ARP request aimed at target, len bytes long. Bytes that the
   // responder does not check are fill, or random where fill is negative.
   function automatic frame_bytes_type arp_frame(input logic [31:0] target,
                                                 input int unsigned len, input int fill);
      frame_bytes_type frame;
      int unsigned     i;
      for (i = 0; i < ((len < 42) ? 42 : len); i++)
         frame = {frame, ((fill < 0) ? 8'($urandom) : 8'(fill))};
      frame[12] = arp_pkg::ETH_ARP[15:8];
      frame[13] = arp_pkg::ETH_ARP[7:0];
      frame[20] = arp_pkg::OPCODE_REQUEST[15:8];
      frame[21] = arp_pkg::OPCODE_REQUEST[7:0];
      for (i = 0; i < 4; i++) frame[38 + i] = target[31 - 8 * i -: 8];
      while (frame.size() > len) void'(frame.pop_back());
      return frame;
   endfunction

   // Register access: a setup phase, then the access phase that ends on the
   // edge where the register changes.
   task automatic csr_write(input logic [1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         arp_pkg::REG_GATEWAY_MAC: answer_mac = value[47:0];
         arp_pkg::REG_GATEWAY_IP:  gateway_addr = value[31:0];
         arp_pkg::REG_DNS_IP:      dns_addr = value[31:0];
         default:                  ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [1:0] index);
      logic [63:0] got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 3'b000};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if (got !== register_value(index))
         report_mismatch($sformatf("register %0d reads %h, expected %h",
                                   index, got, register_value(index)));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_registers();
      csr_read_check(arp_pkg::REG_GATEWAY_MAC);
      csr_read_check(arp_pkg::REG_GATEWAY_IP);
      csr_read_check(arp_pkg::REG_DNS_IP);
   endtask

   // One frame drawn from a mix dominated by valid requests; the rest break
   // exactly one of the checks or are plain noise.
   task automatic send_random_frame();
      frame_bytes_type frame;
      int unsigned     kind;
      int unsigned     len;
      int unsigned     flip;
      logic [31:0]     target;
      kind = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(43, 80) : 42;
      target = $urandom_range(1) ? gateway_addr : dns_addr;
      frame = arp_frame(target, len, -1);
      if (kind < 65) begin
         // Well-formed request to a claimed address.
      end else if (kind < 72) begin
         flip = $urandom_range(15);
         if (flip < 8) frame[13] ^= 8'(1 << flip);
         else frame[12] ^= 8'(1 << (flip - 8));
      end else if (kind < 79) begin
         frame[20] = 8'($urandom);
         frame[21] = 8'($urandom);
      end else if (kind < 86) begin
         target = $urandom;
         frame = arp_frame(target, len, -1);
      end else if (kind < 93) begin
         frame = arp_frame(target, $urandom_range(1, 41), -1);
      end else begin
         frame = arp_frame(target, $urandom_range(1, 64), -1);
         foreach (frame[i]) frame[i] = 8'($urandom);
      end
      send_frame(frame);
   endtask

   // Reset settings: each way a frame is answered or dropped, once.
   task automatic test_frame_cases();
      frame_bytes_type frame;
      send_frame(arp_frame(gateway_addr, 42, -1));
      // All-ones and all-zero payloads, the latter well past 42 bytes.
      send_frame(arp_frame(dns_addr, 42, 8'hff));
      send_frame(arp_frame(gateway_addr, 70, 8'h00));
      // One byte short of a full header, then a frame of one byte.
      send_frame(arp_frame(gateway_addr, 41, -1));
      send_frame(arp_frame(gateway_addr, 1, 8'hff));
      frame = arp_frame(gateway_addr, 42, -1);
      frame[13] = 8'h00;
      send_frame(frame);
      frame = arp_frame(dns_addr, 42, -1);
      frame[21] = arp_pkg::OPCODE_REPLY[7:0];
      send_frame(frame);
      frame = arp_frame(dns_addr, 42, -1);
      frame[20] = 8'h01;
      send_frame(frame);
      send_frame(arp_frame(dns_addr + 32'd1, 42, -1));
      // The byte counter must be back at zero after all those rejects.
      send_frame(arp_frame(dns_addr, 42, -1));
      wait_drained();
   endtask

   // Extreme register values; the upper write bits must be dropped and the
   // unused register slot must change nothing.
   task automatic test_register_extremes();
      csr_write(arp_pkg::REG_GATEWAY_MAC, '1);
      csr_write(arp_pkg::REG_GATEWAY_IP, 64'hffff_ffff_0000_0000);
      csr_write(arp_pkg::REG_DNS_IP, 64'h0000_0000_ffff_ffff);
      check_registers();
      send_frame(arp_frame(32'h0000_0000, 42, -1));
      send_frame(arp_frame(32'hffff_ffff, 42, -1));
      send_frame(arp_frame(32'h0000_0000, 55, -1));
      wait_drained();
      csr_write(arp_pkg::REG_GATEWAY_MAC, 64'hffff_0000_0000_0000);
      csr_write(REG_UNUSED, {$urandom, $urandom});
      check_registers();
      send_frame(arp_frame(gateway_addr, 42, -1));
      send_frame(arp_frame(dns_addr, 42, -1));
      wait_drained();
   endtask

   // Back-to-back requests into a stalling receiver fill the job queue and
   // push back on the sender; then the sender holds off until every reply
   // has left before it sends the next request.
   task automatic test_reply_backlog();
      rsp_stall_pct = 74;
      repeat (4) send_frame(arp_frame(gateway_addr, 42, -1));
      wait_drained();
      send_frame(arp_frame(dns_addr, 42, -1));
      wait_drained();
      rsp_stall_pct = 0;
   endtask

   // Fresh random registers, then random traffic until enough replies were
   // owed in this phase.
   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned replies_wanted);
      int unsigned replies_at_start;
      logic [31:0] claimed;
      claimed = $urandom;
      csr_write(arp_pkg::REG_GATEWAY_MAC, {$urandom, $urandom});
      csr_write(arp_pkg::REG_GATEWAY_IP, {$urandom, claimed});
      // Now and then both addresses are the same one.
      csr_write(arp_pkg::REG_DNS_IP,
                {$urandom, ($urandom_range(3) == 0) ? claimed : $urandom});
      check_registers();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      replies_at_start = replies_predicted;
      while (replies_predicted < replies_at_start + replies_wanted) send_random_frame();
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      check_registers();
      test_frame_cases();
      test_register_extremes();
      test_reply_backlog();
      test_random_traffic(0, 0, 3);
      test_random_traffic(74, 0, 3);
      test_random_traffic(0, 74, 3);
      test_random_traffic(21, 21, 3);

      wait_drained();
      $display("covered %0d frames, %0d ARP replies, %0d reply words checked",
               frames_seen, replies_predicted, words_checked);
      $display("%0d mismatches over %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
